### rtl/mlrq_pkg.sv
// Package for the multilevel ready-queue scheduler.
// Holds the field widths, request and status codes, and the sequencer state type.
// No dependencies.
package mlrq_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned TaskW   = 6;
  localparam int unsigned PrioW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 8;

  localparam logic [ModeW-1:0] ModeAdd    = 2'd0;
  localparam logic [ModeW-1:0] ModeSched  = 2'd1;
  localparam logic [ModeW-1:0] ModeRemove = 2'd2;
  localparam logic [ModeW-1:0] ModeNop    = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StBad      = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;
  localparam logic [StatusW-1:0] StNoReady  = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_ADD    = 10'b00_0000_0010,
    S_RM_RD  = 10'b00_0000_0100,
    S_RM_CMP = 10'b00_0000_1000,
    S_SH_RD  = 10'b00_0001_0000,
    S_SH_WR  = 10'b00_0010_0000,
    S_SCAN   = 10'b00_0100_0000,
    S_TAKE   = 10'b00_1000_0000,
    S_FIN    = 10'b01_0000_0000,
    S_SPARE  = 10'b10_0000_0000
  } seq_state_e;

endpackage

### rtl/mlrq_ram.sv
// Queue entry store: one ring of task indices per level.
// Single write port, single registered read port. Uses mlrq_pkg.
module mlrq_ram #(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned TASKS  = 64,
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int unsigned PW = $clog2(TASKS)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [LW-1:0]             lvl_i,
  input  logic [PW-1:0]             wslot_i,
  input  logic [mlrq_pkg::TaskW-1:0] wdata_i,
  input  logic [PW-1:0]             rslot_i,
  output logic [mlrq_pkg::TaskW-1:0] rdata_o
);
  import mlrq_pkg::*;

  logic [TaskW-1:0] mem [LEVELS][TASKS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[lvl_i][wslot_i] <= wdata_i;
    end
    rdata_o <= mem[lvl_i][rslot_i];
  end

endmodule

### rtl/mlrq_slot.sv
// Shared ring-position unit: (head + position) wrapped at the ring depth.
// One add and one compare-subtract. Uses no package items.
module mlrq_slot #(
  parameter int unsigned TASKS = 64,
  localparam int unsigned PW = $clog2(TASKS),
  localparam int unsigned NW = $clog2(TASKS + 1)
) (
  input  logic [PW-1:0] head_i,
  input  logic [NW-1:0] pos_i,
  output logic [PW-1:0] slot_o
);
  logic [NW:0] sum;

  always_comb begin
    sum = (NW+1)'(head_i) + (NW+1)'(pos_i);
    if (sum >= (NW+1)'(TASKS)) begin
      sum = sum - (NW+1)'(TASKS);
    end
    slot_o = sum[PW-1:0];
  end

endmodule

### rtl/multilevel_ready_queue_scheduler_unit.sv
// Top level of the multilevel ready-queue scheduler.
// Depends on mlrq_pkg, mlrq_ram and mlrq_slot.
//
// Usage:
//   The slave stream carries one request word: add a task at a level,
//   remove a task from a level, or schedule (pick the next task and requeue
//   the running one). The master stream returns one result word per request
//   with a status and, for a successful schedule, the chosen task.
//   One request is worked on at a time by a small
//   sequencer driving one shared ring-position adder and one entry memory
//   port. An add appends at the tail, a schedule scans the levels, and a
//   remove takes a read and a compare per entry searched, then a read and
//   a write per entry moved while closing the gap, as the memory port is
//   registered. The sequencer returns to idle before the next request.
//   s_axis_tready is high only while the sequencer is idle.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls with a result still
//   held, the sequencer holds its next result until the register frees.
//   Reset clears lengths, heads and execute counters; entry storage is not
//   cleared, as only entries inside a queue's length are ever read.
module multilevel_ready_queue_scheduler_unit #(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned TASKS  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] mode, [7:2] task_index, [10:8] priority_req, [11] running_ends
  input  logic [mlrq_pkg::InW-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] status, [7:2] next_task
  output logic [mlrq_pkg::OutW-1:0]  m_axis_tdata
);
  import mlrq_pkg::*;

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PW = $clog2(TASKS);
  localparam int unsigned NW = $clog2(TASKS + 1);
  localparam logic [LW-1:0] LastLvl = LW'(LEVELS - 1);
  localparam logic [NW-1:0] Full    = NW'(TASKS);

  seq_state_e state_q, state_d;

  // request word held while the sequencer works
  logic [TaskW-1:0]   task_q, task_d;
  logic [PrioW-1:0]   prio_q, prio_d;
  logic               ends_q, ends_d;
  logic               requeue_q, requeue_d;
  logic               pass_q, pass_d;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic [NW-1:0]      pos_q, pos_d;
  logic [StatusW-1:0] res_st_q, res_st_d;
  logic [TaskW-1:0]   res_nx_q, res_nx_d;

  logic [NW-1:0] len_q [LEVELS];
  logic [NW-1:0] len_d [LEVELS];
  logic [PW-1:0] head_q [LEVELS];
  logic [PW-1:0] head_d [LEVELS];
  logic [NW-1:0] cnt_q [LEVELS];
  logic [NW-1:0] cnt_d [LEVELS];

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_st_q, out_st_d;
  logic [TaskW-1:0]   out_nx_q, out_nx_d;

  // shared ring unit and memory port
  logic [NW-1:0]    slot_pos;
  logic [PW-1:0]    slot;
  logic             we;
  logic [PW-1:0]    wslot;
  logic [PW-1:0]    rslot;
  logic [TaskW-1:0] wdata;
  logic [TaskW-1:0] rdata;

  logic [ModeW-1:0] in_mode;
  logic [TaskW-1:0] in_task;
  logic [PrioW-1:0] in_prio;
  logic             any_ready;
  logic             in_bad;
  logic             prio_bad;

  assign in_mode = s_axis_tdata[1:0];
  assign in_task = s_axis_tdata[7:2];
  assign in_prio = s_axis_tdata[10:8];
  assign in_bad  = 32'(in_prio) >= LEVELS;
  assign prio_bad = 32'(prio_q) >= LEVELS;

  always_comb begin
    any_ready = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      any_ready = any_ready | (len_q[i] != '0);
    end
  end

  mlrq_slot #(.TASKS(TASKS)) u_slot (
    .head_i (head_q[lvl_q]),
    .pos_i  (slot_pos),
    .slot_o (slot)
  );

  mlrq_ram #(.LEVELS(LEVELS), .TASKS(TASKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .lvl_i   (lvl_q),
    .wslot_i (wslot),
    .wdata_i (wdata),
    .rslot_i (rslot),
    .rdata_o (rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_nx_q, out_st_q};

  always_comb begin
    state_d     = state_q;
    task_d      = task_q;
    prio_d      = prio_q;
    ends_d      = ends_q;
    requeue_d   = requeue_q;
    pass_d      = pass_q;
    lvl_d       = lvl_q;
    pos_d       = pos_q;
    res_st_d    = res_st_q;
    res_nx_d    = res_nx_q;
    len_d       = len_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_nx_d    = out_nx_q;
    slot_pos    = pos_q;
    we          = 1'b0;
    wslot       = slot;
    rslot       = slot;
    wdata       = task_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          task_d    = in_task;
          prio_d    = in_prio;
          ends_d    = s_axis_tdata[11];
          requeue_d = 1'b0;
          pass_d    = 1'b0;
          pos_d     = '0;
          res_st_d  = StOk;
          res_nx_d  = '0;
          lvl_d     = in_prio[LW-1:0];
          case (in_mode)
            ModeAdd: state_d = S_ADD;
            ModeRemove: begin
              if (in_bad) begin
                res_st_d = StBad;
                state_d  = S_FIN;
              end else begin
                state_d = S_RM_RD;
              end
            end
            ModeSched: begin
              lvl_d = '0;
              if (!any_ready) begin
                res_st_d = StNoReady;
                state_d  = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // append at the tail; a requeue that fails is dropped silently
      S_ADD: begin
        slot_pos = len_q[lvl_q];
        if (prio_bad || len_q[lvl_q] >= Full) begin
          if (!requeue_q) begin
            res_st_d = StBad;
          end
        end else begin
          we           = 1'b1;
          len_d[lvl_q] = len_q[lvl_q] + 1'b1;
        end
        state_d = S_FIN;
      end

      S_RM_RD: begin
        if (pos_q >= len_q[lvl_q]) begin
          res_st_d = StNotFound;
          state_d  = S_FIN;
        end else begin
          state_d = S_RM_CMP;
        end
      end

      S_RM_CMP: begin
        if (rdata == task_q) begin
          state_d = S_SH_RD;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_RM_RD;
        end
      end

      // close the gap: read entry pos+1, then write it at pos
      S_SH_RD: begin
        slot_pos = pos_q + 1'b1;
        if (pos_q + 1'b1 >= len_q[lvl_q]) begin
          len_d[lvl_q] = len_q[lvl_q] - 1'b1;
          state_d      = S_FIN;
        end else begin
          state_d = S_SH_WR;
        end
      end

      S_SH_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        pos_d   = pos_q + 1'b1;
        state_d = S_SH_RD;
      end

      // one level per cycle, two passes at most
      S_SCAN: begin
        slot_pos = NW'(1);
        rslot    = head_q[lvl_q];
        if (cnt_q[lvl_q] < len_q[lvl_q]) begin
          head_d[lvl_q] = slot;
          len_d[lvl_q]  = len_q[lvl_q] - 1'b1;
          cnt_d[lvl_q]  = cnt_q[lvl_q] + 1'b1;
          state_d       = S_TAKE;
        end else begin
          cnt_d[lvl_q] = '0;
          if (lvl_q == LastLvl) begin
            lvl_d = '0;
            if (pass_q) begin
              res_st_d = StNoReady;
              state_d  = S_FIN;
            end else begin
              pass_d = 1'b1;
            end
          end else begin
            lvl_d = lvl_q + 1'b1;
          end
        end
      end

      S_TAKE: begin
        res_nx_d = rdata;
        if (ends_q) begin
          state_d = S_FIN;
        end else begin
          requeue_d = 1'b1;
          lvl_d     = prio_q[LW-1:0];
          state_d   = S_ADD;
        end
      end

      // hold the result until the output register frees
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_nx_d    = res_nx_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        len_q[i]  <= '0;
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q    <= task_d;
    prio_q    <= prio_d;
    ends_q    <= ends_d;
    requeue_q <= requeue_d;
    pass_q    <= pass_d;
    lvl_q     <= lvl_d;
    pos_q     <= pos_d;
    res_st_q  <= res_st_d;
    res_nx_q  <= res_nx_d;
    out_st_q  <= out_st_d;
    out_nx_q  <= out_nx_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while sequencer busy");

  a_take_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAKE |-> $past(state_q) == S_SCAN)
    else $error("pop data latched without a scan hit");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> len_q[lvl_q] <= Full)
    else $error("queue length beyond ring depth");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && (!out_valid_q || m_axis_tready) |=> m_axis_tvalid)
    else $error("finished result not presented");

endmodule
